@@ hdl/hpt_pkg.sv @@
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants of the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COMP_W        = 32;            // one coordinate or coefficient
  localparam int DIM           = 4;             // x, y, z, w
  localparam int PROD_W        = 2 * COMP_W;    // one full product
  localparam int PAIR_W        = PROD_W + 1;    // sum of two products
  localparam int SUM_W         = PROD_W + 2;    // sum of four products
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 2 * COMP_W;
  localparam int NUM_REGS      = 8;
  localparam int REG_SEL_W     = $clog2(NUM_REGS);

  // Register indexes
  localparam logic [REG_SEL_W-1:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_ROW2_COLS01 = 3'd4;
  localparam logic [REG_SEL_W-1:0] REG_ROW2_COLS23 = 3'd5;
  localparam logic [REG_SEL_W-1:0] REG_ROW3_COLS01 = 3'd6;
  localparam logic [REG_SEL_W-1:0] REG_ROW3_COLS23 = 3'd7;

  typedef struct packed {
    logic signed [COMP_W-1:0] x_in;
    logic signed [COMP_W-1:0] y_in;
    logic signed [COMP_W-1:0] z_in;
    logic signed [COMP_W-1:0] w_in;
    logic                     last_point;
  } point_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] x_out;
    logic signed [COMP_W-1:0] y_out;
    logic signed [COMP_W-1:0] z_out;
    logic signed [COMP_W-1:0] w_out;
    logic                     last_out;
    logic                     clipped;
  } result_t;

  typedef logic [DIM-1:0][COMP_W-1:0] vec_t;
  typedef logic [DIM-1:0][DIM-1:0][COMP_W-1:0] coef_mat_t;

  // Per-stage load enables of the lane pipeline
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } adv_t;

  typedef struct packed {
    logic [COMP_W-1:0] value;
    logic              sat;
  } lane_res_t;

  typedef lane_res_t [DIM-1:0] lane_vec_t;

endpackage

@@ hdl/hpt_if.sv @@
// ----------------------------------------------------------------------------
// hpt_if
// Valid/ready channels of the point transform: points, results, config.
// ----------------------------------------------------------------------------
interface hpt_point_if;
  logic            valid;
  logic            ready;
  hpt_pkg::point_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hpt_result_if;
  logic             valid;
  logic             ready;
  hpt_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hpt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hpt_pkg::CFG_IDX_W-1:0]  index;
  logic [hpt_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/hpt_coef_regs.sv @@
// ----------------------------------------------------------------------------
// hpt_coef_regs
// Eight 64-bit matrix registers, reset to identity, unpacked to 4x4 coefs.
// ----------------------------------------------------------------------------
module hpt_coef_regs #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  hpt_cfg_if.sink            cfg,
  output hpt_pkg::coef_mat_t coef
);

  localparam int CompW = hpt_pkg::COMP_W;
  localparam logic [CompW-1:0] One  = CompW'(1) << FRAC_BITS;
  localparam logic [CompW-1:0] Zero = '0;

  logic [hpt_pkg::CFG_DATA_W-1:0] regs [hpt_pkg::NUM_REGS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[hpt_pkg::REG_ROW0_COLS01] <= {Zero, One};
      regs[hpt_pkg::REG_ROW0_COLS23] <= {Zero, Zero};
      regs[hpt_pkg::REG_ROW1_COLS01] <= {One, Zero};
      regs[hpt_pkg::REG_ROW1_COLS23] <= {Zero, Zero};
      regs[hpt_pkg::REG_ROW2_COLS01] <= {Zero, Zero};
      regs[hpt_pkg::REG_ROW2_COLS23] <= {Zero, One};
      regs[hpt_pkg::REG_ROW3_COLS01] <= {Zero, Zero};
      regs[hpt_pkg::REG_ROW3_COLS23] <= {One, Zero};
    end else if (cfg.valid && (cfg.index < hpt_pkg::CFG_IDX_W'(hpt_pkg::NUM_REGS))) begin
      // indexes past the last register are dropped
      regs[cfg.index[hpt_pkg::REG_SEL_W-1:0]] <= cfg.data;
    end
  end

  // register 2r+h: low half is column 2h, high half column 2h+1
  for (genvar r = 0; r < hpt_pkg::DIM; r++) begin : g_row
    for (genvar c = 0; c < hpt_pkg::DIM; c++) begin : g_col
      assign coef[r][c] = regs[2 * r + c / 2][CompW * (c % 2) +: CompW];
    end
  end

endmodule

@@ hdl/hpt_lane.sv @@
// ----------------------------------------------------------------------------
// hpt_lane
// One matrix row: four products, two-level add with rounding, saturation.
// ----------------------------------------------------------------------------
module hpt_lane #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  hpt_pkg::adv_t                              adv,
  input  logic [hpt_pkg::DIM-1:0][hpt_pkg::COMP_W-1:0] row,
  input  hpt_pkg::vec_t                              pt,
  output hpt_pkg::lane_res_t                         res
);

  localparam int SumW  = hpt_pkg::SUM_W;
  localparam int CompW = hpt_pkg::COMP_W;
  localparam logic signed [SumW-1:0] Rnd    = SumW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SumW-1:0] SatMax = SumW'({1'b0, {(CompW-1){1'b1}}});
  localparam logic signed [SumW-1:0] SatMin = -(SumW'(1) << (CompW - 1));

  logic signed [hpt_pkg::PROD_W-1:0] prod [hpt_pkg::DIM];
  logic signed [hpt_pkg::PAIR_W-1:0] pair [2];
  logic signed [SumW-1:0]            total;
  logic signed [SumW-1:0]            shifted;

  always_ff @(posedge clk) begin
    if (adv.en1) begin
      for (int c = 0; c < hpt_pkg::DIM; c++) begin
        prod[c] <= $signed(row[c]) * $signed(pt[c]);
      end
    end
    if (adv.en2) begin
      pair[0] <= {prod[0][hpt_pkg::PROD_W-1], prod[0]} + {prod[1][hpt_pkg::PROD_W-1], prod[1]};
      pair[1] <= {prod[2][hpt_pkg::PROD_W-1], prod[2]} + {prod[3][hpt_pkg::PROD_W-1], prod[3]};
    end
    if (adv.en3) begin
      total <= {pair[0][hpt_pkg::PAIR_W-1], pair[0]}
             + {pair[1][hpt_pkg::PAIR_W-1], pair[1]} + Rnd;
    end
  end

  // floor shift, then clamp to the 32-bit range
  always_comb begin
    shifted = total >>> FRAC_BITS;
    if (shifted > SatMax) begin
      res.value = SatMax[CompW-1:0];
      res.sat   = 1'b1;
    end else if (shifted < SatMin) begin
      res.value = SatMin[CompW-1:0];
      res.sat   = 1'b1;
    end else begin
      res.value = shifted[CompW-1:0];
      res.sat   = 1'b0;
    end
  end

endmodule

@@ hdl/hpt_merge.sv @@
// ----------------------------------------------------------------------------
// hpt_merge
// Output register: gathers the four lane results and folds their clip flags.
// ----------------------------------------------------------------------------
module hpt_merge (
  input  logic               clk,
  input  logic               load,
  input  hpt_pkg::lane_vec_t lanes,
  input  logic               last,
  output hpt_pkg::result_t   res
);

  logic any_sat;

  always_comb begin
    any_sat = 1'b0;
    for (int i = 0; i < hpt_pkg::DIM; i++) begin
      any_sat = any_sat | lanes[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.x_out    <= lanes[0].value;
      res.y_out    <= lanes[1].value;
      res.z_out    <= lanes[2].value;
      res.w_out    <= lanes[3].value;
      res.last_out <= last;
      res.clipped  <= any_sat;
    end
  end

endmodule

@@ hdl/homogeneous_point_transform.sv @@
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 matrix times homogeneous Q16.16 point, rounded and saturated.
// ----------------------------------------------------------------------------
// Channels: pt takes one point (x, y, z, w, last mark) per beat; res gives
// one transformed point per beat with the last mark and a clip flag; cfg
// writes one 64-bit matrix register (index 0..7, two coefficients each).
// Writes to indexes above seven are dropped. Write cfg only while idle.
// Four lanes, one per matrix row, each run four 32x32 multipliers, a pair
// add, a final add with rounding, then clamp; the output register merges them.
// Path: an accepted point passes the product, pair-sum and total registers,
// then the output register, to res; one point per clock while res is ready.
// Stalls: each stage holds only while it is full and the next is blocked,
// so bubbles are squeezed out and pt stays ready until every stage, output
// register included, holds a point.
// Reset: clears all stage valids and loads the identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  hpt_point_if.sink     pt,
  hpt_result_if.source  res,
  hpt_cfg_if.sink       cfg
);

  localparam logic signed [hpt_pkg::COMP_W-1:0] MaxV = {1'b0, {(hpt_pkg::COMP_W-1){1'b1}}};
  localparam logic signed [hpt_pkg::COMP_W-1:0] MinV = {1'b1, {(hpt_pkg::COMP_W-1){1'b0}}};

  hpt_pkg::coef_mat_t coef;
  hpt_pkg::vec_t      pt_vec;
  hpt_pkg::adv_t      adv;
  hpt_pkg::lane_vec_t lanes;

  logic v1, v2, v3, ov;
  logic l1, l2, l3;
  logic rdy1, rdy2, rdy3, load_out;

  assign load_out = !ov || res.ready;
  assign rdy3     = !v3 || load_out;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;

  assign pt.ready  = rdy1;
  assign res.valid = ov;
  assign adv.en1   = rdy1;
  assign adv.en2   = rdy2;
  assign adv.en3   = rdy3;

  assign pt_vec = {pt.data.w_in, pt.data.z_in, pt.data.y_in, pt.data.x_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (rdy1) v1 <= pt.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (load_out) ov <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) l1 <= pt.data.last_point;
    if (rdy2) l2 <= l1;
    if (rdy3) l3 <= l2;
  end

  hpt_coef_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .coef (coef)
  );

  for (genvar i = 0; i < hpt_pkg::DIM; i++) begin : g_lane
    hpt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk (clk),
      .adv (adv),
      .row (coef[i]),
      .pt  (pt_vec),
      .res (lanes[i])
    );
  end

  hpt_merge u_merge (
    .clk   (clk),
    .load  (load_out),
    .lanes (lanes),
    .last  (l3),
    .res   (res.data)
  );

  // an accepted point always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pt.valid && pt.ready) |=> v1)
    else $error("accepted beat lost at stage 1");

  // input only backs up when every stage is occupied
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !pt.ready |-> (v1 && v2 && v3 && ov))
    else $error("input stalled with a bubble in the pipeline");

  // a point leaving the last lane stage reaches the output register
  a_merge_load: assert property (@(posedge clk) disable iff (rst)
    (v3 && load_out) |=> ov)
    else $error("lane result dropped at merge");

  // a clipped result carries at least one clamped component
  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.clipped) |->
      (res.data.x_out == MaxV || res.data.x_out == MinV ||
       res.data.y_out == MaxV || res.data.y_out == MinV ||
       res.data.z_out == MaxV || res.data.z_out == MinV ||
       res.data.w_out == MaxV || res.data.w_out == MinV))
    else $error("clip flag without a clamped component");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the homogeneous point transform: a directed set of edge
// points under identity, all-max, all-min and half-diagonal matrices, then
// random affine and general matrices with random points. Every result beat
// is checked field by field against a 4x4 fixed-point transform kept in the
// bench, under random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAC      = hpt_pkg::FRAC_BITS_DEF;
  localparam int COMP_W    = hpt_pkg::COMP_W;
  localparam int DIM       = hpt_pkg::DIM;
  localparam int ACC_W     = hpt_pkg::SUM_W + 1;
  localparam int IDLE_PCT  = 13;
  localparam int SETTLE    = 8;
  localparam int HOLD_AT   = 400;
  localparam int HOLD_LEN  = 300;
  localparam int PHASE_PTS = 250;
  localparam int N_PHASES  = 7;
  localparam int CALM_PH   = 4;

  localparam logic signed [COMP_W-1:0] S_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COMP_W-1:0] S_MIN = 32'sh80000000;
  localparam logic signed [COMP_W-1:0] ONE   = 1 <<< FRAC;
  localparam logic signed [COMP_W-1:0] HALF  = 1 <<< (FRAC - 1);
  localparam longint SAT_HI     = 64'sh7FFFFFFF;
  localparam longint SAT_LO     = -64'sh80000000;
  localparam longint ROUND_HALF = 64'sd1 <<< (FRAC - 1);

  typedef logic signed [COMP_W-1:0] mat_t [DIM][DIM];
  typedef enum {M_RANDOM, M_AFFINE, M_PROJECT, M_ALL_MAX, M_ALL_MIN, M_HALF_DIAG} mat_style_e;

  logic clk;
  logic rst;
  logic calm;
  logic pt_took;
  int   errors;
  int   res_beats;
  int   hold_left;
  logic hold_done;

  mat_t             mat_q;
  hpt_pkg::point_t  pending_pts[$];
  hpt_pkg::result_t expected_pts[$];

  hpt_point_if  pt_ch();
  hpt_result_if res_ch();
  hpt_cfg_if    cfg_ch();

  homogeneous_point_transform #(.FRAC_BITS(FRAC)) dut (
    .clk (clk),
    .rst (rst),
    .pt  (pt_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always #1 clk = ~clk;

  initial begin
    #200us;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Row i of the matrix times the point, rounded to nearest and clamped
  function automatic hpt_pkg::result_t transform_point(hpt_pkg::point_t p);
    logic signed [COMP_W-1:0] v [DIM];
    logic signed [COMP_W-1:0] o [DIM];
    logic signed [ACC_W-1:0]  acc;
    hpt_pkg::result_t r;
    v[0] = p.x_in;
    v[1] = p.y_in;
    v[2] = p.z_in;
    v[3] = p.w_in;
    r = '0;
    for (int i = 0; i < DIM; i++) begin
      acc = ROUND_HALF;
      for (int c = 0; c < DIM; c++) acc += mat_q[i][c] * v[c];
      acc = acc >>> FRAC;
      if (acc > SAT_HI) begin
        o[i] = S_MAX;
        r.clipped = 1'b1;
      end else if (acc < SAT_LO) begin
        o[i] = S_MIN;
        r.clipped = 1'b1;
      end else begin
        o[i] = acc[COMP_W-1:0];
      end
    end
    r.x_out    = o[0];
    r.y_out    = o[1];
    r.z_out    = o[2];
    r.w_out    = o[3];
    r.last_out = p.last_point;
    return r;
  endfunction

  function automatic hpt_pkg::point_t mk_pt(input logic signed [COMP_W-1:0] x, y, z, w,
                                            input logic last);
    hpt_pkg::point_t p;
    p.x_in       = x;
    p.y_in       = y;
    p.z_in       = z;
    p.w_in       = w;
    p.last_point = last;
    return p;
  endfunction

  // Random value sign-extended from the given width
  function automatic logic signed [COMP_W-1:0] small_rand(int bits);
    return $signed($urandom) >>> (COMP_W - bits);
  endfunction

  function automatic logic signed [COMP_W-1:0] corner_val();
    case ($urandom_range(4))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return -1;
      default: return ONE;
    endcase
  endfunction

  // Half well-formed points (w = 1.0), plus full-range, corner and small noise
  function automatic hpt_pkg::point_t random_point();
    logic signed [COMP_W-1:0] v [DIM];
    int kind;
    kind = $urandom_range(9);
    for (int c = 0; c < DIM; c++) begin
      if (kind < 3)      v[c] = $urandom;
      else if (kind < 8) v[c] = (c == DIM - 1) ? ONE : small_rand(24);
      else if (kind == 8) v[c] = corner_val();
      else               v[c] = small_rand(20);
    end
    return mk_pt(v[0], v[1], v[2], v[3], $urandom_range(7) == 0);
  endfunction

  function automatic mat_t make_matrix(mat_style_e s);
    mat_t m;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        case (s)
          M_RANDOM:  m[r][c] = $urandom;
          M_AFFINE: begin
            if (r == DIM - 1)      m[r][c] = (c == DIM - 1) ? ONE : '0;
            else if (c == DIM - 1) m[r][c] = small_rand(25);
            else                   m[r][c] = small_rand(19);
          end
          M_PROJECT: m[r][c] = small_rand(19);
          M_ALL_MAX: m[r][c] = S_MAX;
          M_ALL_MIN: m[r][c] = S_MIN;
          default:   m[r][c] = (r == c) ? HALF : '0;
        endcase
      end
    end
    return m;
  endfunction

  task automatic write_reg(input logic [hpt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hpt_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_matrix(input mat_t m);
    for (int r = 0; r < DIM; r++) begin
      for (int h = 0; h < 2; h++) begin
        write_reg(hpt_pkg::CFG_IDX_W'(2 * r + h), {m[r][2 * h + 1], m[r][2 * h]});
      end
    end
  endtask

  // Out-of-range index; the block must drop it
  task automatic write_stray();
    write_reg(hpt_pkg::CFG_IDX_W'($urandom_range((1 << hpt_pkg::CFG_IDX_W) - 1,
                                                 hpt_pkg::NUM_REGS)),
              {$urandom, $urandom});
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_pts.size() != 0 || pt_ch.valid || expected_pts.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Point driver
  always @(negedge clk) begin
    hpt_pkg::point_t nxt;
    logic            offer;
    if (rst) begin
      pt_ch.valid <= 1'b0;
    end else if (!pt_ch.valid || pt_took) begin
      offer = pending_pts.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT);
      if (offer) begin
        nxt = pending_pts.pop_front();
        pt_ch.data <= nxt;
      end
      pt_ch.valid <= offer;
    end
  end

  // Result sink: random back-pressure, one long hold-off to fill the pipe
  always @(negedge clk) begin
    if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && res_beats >= HOLD_AT) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_LEN;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Matrix shadow, expected-point store and result checks
  always @(posedge clk) begin
    hpt_pkg::result_t want;
    hpt_pkg::result_t got;
    if (rst) begin
      pt_took <= 1'b0;
      for (int r = 0; r < DIM; r++)
        for (int c = 0; c < DIM; c++) mat_q[r][c] <= (r == c) ? ONE : '0;
    end else begin
      pt_took <= pt_ch.valid && pt_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < hpt_pkg::NUM_REGS) begin
        mat_q[cfg_ch.index >> 1][(cfg_ch.index & 1) * 2] <=
          cfg_ch.data[COMP_W-1:0];
        mat_q[cfg_ch.index >> 1][(cfg_ch.index & 1) * 2 + 1] <=
          cfg_ch.data[hpt_pkg::CFG_DATA_W-1:COMP_W];
      end
      if (pt_ch.valid && pt_ch.ready) expected_pts.push_back(transform_point(pt_ch.data));
      if (res_ch.valid && res_ch.ready) begin
        res_beats <= res_beats + 1;
        got = res_ch.data;
        if (expected_pts.size() == 0) begin
          $error("result beat with no point outstanding");
          errors++;
        end else begin
          want = expected_pts.pop_front();
          if (got.x_out !== want.x_out) begin
            $error("x_out: expected %0d, got %0d", want.x_out, got.x_out);
            errors++;
          end
          if (got.y_out !== want.y_out) begin
            $error("y_out: expected %0d, got %0d", want.y_out, got.y_out);
            errors++;
          end
          if (got.z_out !== want.z_out) begin
            $error("z_out: expected %0d, got %0d", want.z_out, got.z_out);
            errors++;
          end
          if (got.w_out !== want.w_out) begin
            $error("w_out: expected %0d, got %0d", want.w_out, got.w_out);
            errors++;
          end
          if (got.last_out !== want.last_out) begin
            $error("last_out: expected %0d, got %0d", want.last_out, got.last_out);
            errors++;
          end
          if (got.clipped !== want.clipped) begin
            $error("clipped: expected %0d, got %0d", want.clipped, got.clipped);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    mat_style_e rand_styles [N_PHASES];
    rand_styles = '{M_AFFINE, M_RANDOM, M_AFFINE, M_PROJECT, M_AFFINE, M_RANDOM, M_AFFINE};
    clk          = 1'b0;
    rst          = 1'b1;
    calm         = 1'b0;
    errors       = 0;
    res_beats    = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    pt_took      = 1'b0;
    pt_ch.valid  = 1'b0;
    pt_ch.data   = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity from reset
    pending_pts.push_back(mk_pt(0, 0, 0, 0, 1'b0));
    pending_pts.push_back(mk_pt(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1));
    pending_pts.push_back(mk_pt(S_MIN, S_MIN, S_MIN, S_MIN, 1'b0));
    pending_pts.push_back(mk_pt(S_MAX, S_MIN, -1, 1, 1'b1));
    pending_pts.push_back(mk_pt(ONE, -ONE, 0, ONE, 1'b0));
    pending_pts.push_back(mk_pt(12345678, -7654321, 1, ONE, 1'b1));
    wait_drained();

    // every coefficient at max: large points clip both ways
    load_matrix(make_matrix(M_ALL_MAX));
    write_reg(hpt_pkg::CFG_IDX_W'(hpt_pkg::NUM_REGS), '0);
    write_reg('1, '0);
    pending_pts.push_back(mk_pt(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1));
    pending_pts.push_back(mk_pt(S_MIN, S_MIN, S_MIN, S_MIN, 1'b0));
    pending_pts.push_back(mk_pt(0, 0, 0, 0, 1'b1));
    pending_pts.push_back(mk_pt(1, 0, 0, 0, 1'b0));
    pending_pts.push_back(mk_pt(S_MAX, S_MIN, S_MAX, S_MIN, 1'b1));
    wait_drained();

    // every coefficient at min: sum of four 2^62 products needs 65+ bits
    load_matrix(make_matrix(M_ALL_MIN));
    pending_pts.push_back(mk_pt(S_MIN, S_MIN, S_MIN, S_MIN, 1'b0));
    pending_pts.push_back(mk_pt(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1));
    pending_pts.push_back(mk_pt(S_MIN, S_MIN, S_MIN, 0, 1'b0));
    pending_pts.push_back(mk_pt(0, 0, 0, 0, 1'b1));
    wait_drained();

    // 0.5 on the diagonal: ties round up, negative ties toward zero
    load_matrix(make_matrix(M_HALF_DIAG));
    pending_pts.push_back(mk_pt(1, -1, 3, -3, 1'b0));
    pending_pts.push_back(mk_pt(-1, 1, -3, 3, 1'b1));
    pending_pts.push_back(mk_pt(S_MAX, S_MIN, ONE, -ONE, 1'b0));
    pending_pts.push_back(mk_pt(2, -2, 5, -5, 1'b1));
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      load_matrix(make_matrix(rand_styles[ph]));
      write_stray();
      calm = (ph == CALM_PH);
      for (int i = 0; i < PHASE_PTS; i++) pending_pts.push_back(random_point());
      wait_drained();
    end
    calm = 1'b0;

    if (expected_pts.size() != 0) begin
      $error("%0d expected points never came out", expected_pts.size());
      errors++;
    end
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
